>>> rtl/core/text_cell_to_escape_encoder_assert.svh
// Assertion macros for the text cell escape encoder.
// No dependencies.
`ifndef TEXT_CELL_TO_ESCAPE_ENCODER_ASSERT_SVH
`define TEXT_CELL_TO_ESCAPE_ENCODER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/tce_pkg.sv
// Shared types and constants of the text cell escape encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;
  localparam logic [31:0] CtrlMap = 32'h0800f501;
  localparam logic [7:0] ChEsc = 8'd27;
  localparam logic [7:0] ChLbr = 8'h5b;
  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChM = 8'h6d;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChPct = 8'h25;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChAt = 8'h40;

  localparam logic [1:0] CfgMono = 2'd0;
  localparam logic [1:0] CfgWidth = 2'd1;
  localparam logic [1:0] CfgCol = 2'd2;
  localparam logic [1:0] CfgRow = 2'd3;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdDivStep, CmdDecRow, CmdDecCol, CmdDecCurRow, CmdDecCurCol,
    CmdDecStep, CmdCommit
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } tce_cmd_t;

  typedef struct packed {
    logic div_done;
    logic conv_done;
    logic first;
    logic last;
    logic mono;
    logic attr_chg;
    logic color_chg;
    logic fore_new;
    logic back_new;
    logic fore_bright;
    logic is_ctrl;
    logic is_csi;
    logic mono_bold;
    logic mono_rev;
    logic [7:0] code;
    logic [3:0] fore_map;
    logic [3:0] back_map;
    logic [19:0] bcd;
    logic [2:0] d_cnt;
  } tce_sts_t;

  function automatic logic [2:0] color_map(input logic [2:0] c);
    logic [2:0] r;
    r = {c[0], c[1], c[2]};
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/tce_datapath.sv
// Datapath: registers, held cell, offset divider, decimal converter.
// Depends on tce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tce_datapath import tce_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic [33:0] cell_i,
  input  wire tce_cmd_t    cmd_i,
  output tce_sts_t         sts_o
);
  logic mono_q;
  logic [7:0] width_q, ccol_q, crow_q;
  logic run_v_q, sent_v_q, fore_v_q, back_v_q;
  logic [7:0] run_c_q, sent_c_q;
  logic [3:0] fore_q;
  logic [2:0] back_q;
  logic [15:0] off_q;
  logic [7:0] code_q, attr_q;
  logic first_q, last_q;
  logic [15:0] quo_q;
  logic [8:0] rem_q;
  logic [4:0] step_q;
  logic [16:0] bin_q;
  logic [19:0] bcd_q;
  logic [19:0] bcd_adj;
  logic [4:0] cstep_q;
  logic [8:0] w9;
  logic [9:0] trial;
  logic attr_chg;
  logic [3:0] fore;
  logic [2:0] back;

  assign w9 = (width_q == 8'd0) ? 9'd256 : {1'b0, width_q};
  assign trial = {rem_q, off_q[15]} - {1'b0, w9};
  assign attr_chg = !run_v_q || (attr_q != run_c_q) || first_q;
  assign fore = attr_q[3:0];
  assign back = attr_q[6:4];

  // shift-and-add-3 binary to BCD, one bit per step
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                   : bcd_q[4*k +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
      width_q <= 8'd80;
      ccol_q <= 8'd0;
      crow_q <= 8'd0;
      run_v_q <= 1'b0;
      sent_v_q <= 1'b0;
      fore_v_q <= 1'b0;
      back_v_q <= 1'b0;
      run_c_q <= 8'd0;
      sent_c_q <= 8'd0;
      fore_q <= 4'd0;
      back_q <= 3'd0;
      off_q <= 16'd0;
      code_q <= 8'd0;
      attr_q <= 8'd0;
      first_q <= 1'b0;
      last_q <= 1'b0;
      quo_q <= 16'd0;
      rem_q <= 9'd0;
      step_q <= 5'd0;
      bin_q <= 17'd0;
      bcd_q <= 20'd0;
      cstep_q <= 5'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMono: mono_q <= cfg_data_i[0];
          CfgWidth: width_q <= cfg_data_i;
          CfgCol: ccol_q <= cfg_data_i;
          CfgRow: crow_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.cmd)
        CmdLoad: begin
          {off_q, code_q, attr_q, first_q, last_q} <= cell_i;
          rem_q <= 9'd0;
          step_q <= 5'd0;
        end
        CmdDivStep: begin
          if (!trial[9]) rem_q <= trial[8:0];
          else rem_q <= {rem_q[7:0], off_q[15]};
          off_q <= {off_q[14:0], 1'b0};
          quo_q <= {quo_q[14:0], !trial[9]};
          step_q <= step_q + 5'd1;
        end
        CmdDecRow: begin
          bin_q <= {1'b0, quo_q} + 17'd1;
          bcd_q <= 20'd0;
          cstep_q <= 5'd0;
        end
        CmdDecCol: begin
          bin_q <= {8'd0, rem_q} + 17'd1;
          bcd_q <= 20'd0;
          cstep_q <= 5'd0;
        end
        CmdDecCurRow: begin
          bin_q <= {9'd0, crow_q} + 17'd1;
          bcd_q <= 20'd0;
          cstep_q <= 5'd0;
        end
        CmdDecCurCol: begin
          bin_q <= {9'd0, ccol_q} + 17'd1;
          bcd_q <= 20'd0;
          cstep_q <= 5'd0;
        end
        CmdDecStep: begin
          bcd_q <= {bcd_adj[18:0], bin_q[16]};
          bin_q <= {bin_q[15:0], 1'b0};
          cstep_q <= cstep_q + 5'd1;
        end
        CmdCommit: begin
          if (attr_chg) begin
            run_v_q <= 1'b1;
            run_c_q <= attr_q;
            if (!mono_q && !(sent_v_q && attr_q == sent_c_q)) begin
              sent_v_q <= 1'b1;
              sent_c_q <= attr_q;
              fore_v_q <= 1'b1;
              fore_q <= fore;
              back_v_q <= 1'b1;
              back_q <= back;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.bcd = bcd_q;
  assign sts_o.d_cnt = (bcd_q[19:16] != 4'd0) ? 3'd4 :
                       (bcd_q[15:12] != 4'd0) ? 3'd3 :
                       (bcd_q[11:8] != 4'd0) ? 3'd2 :
                       (bcd_q[7:4] != 4'd0) ? 3'd1 : 3'd0;
  assign sts_o.conv_done = cstep_q == 5'd17;

  assign sts_o.div_done = step_q == 5'd16;
  assign sts_o.first = first_q;
  assign sts_o.last = last_q;
  assign sts_o.mono = mono_q;
  assign sts_o.attr_chg = attr_chg;
  assign sts_o.color_chg = !(sent_v_q && attr_q == sent_c_q);
  assign sts_o.fore_new = !fore_v_q || fore != fore_q;
  assign sts_o.back_new = !back_v_q || back != back_q;
  assign sts_o.fore_bright = fore[3];
  assign sts_o.is_ctrl = code_q < 8'd32 && CtrlMap[code_q[4:0]];
  assign sts_o.is_csi = code_q == 8'd155;
  assign sts_o.mono_bold = attr_q == 8'h0f;
  assign sts_o.mono_rev = attr_q == 8'h70;
  assign sts_o.code = code_q;
  assign sts_o.fore_map = {1'b0, color_map(fore[2:0])};
  assign sts_o.back_map = {1'b0, color_map(back)};
endmodule
`default_nettype wire

>>> rtl/core/tce_ctrl.sv
// Controller: sequences the escape bytes of one cell onto the output.
// Depends on tce_pkg and text_cell_to_escape_encoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
module tce_ctrl import tce_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire tce_sts_t   sts_i,
  output tce_cmd_t        cmd_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  typedef enum logic [3:0] {
    Idle, Div, ConvLd, Conv, GoRow, GoCol, Attr, Char, Reset, CurRow, CurCol, Done
  } state_e;
  state_e st_q;
  state_e nxt_q;
  logic [5:0] idx_q;
  logic ov_q;
  logic [7:0] ob_q;
  logic ol_q;

  // byte generator: returns byte, end-of-phase flag for the given phase/idx
  function automatic logic [8:0] dec_seq(input logic [5:0] i, input logic lead,
                                         input logic trail, input tce_sts_t s);
    // emits [ESC '[']? digits [';' | 'H']; lead: ESC [ prefix; trail: H else ;
    logic [5:0] n;
    logic [5:0] k;
    logic [2:0] p;
    logic [7:0] b;
    n = lead ? 6'd2 : 6'd0;
    k = i - n;
    p = s.d_cnt - k[2:0];
    b = 8'd0;
    if (lead && i == 0) b = ChEsc;
    else if (lead && i == 1) b = ChLbr;
    else if (k <= {3'd0, s.d_cnt}) begin
      case (p)
        3'd0: b = ChZero + {4'd0, s.bcd[3:0]};
        3'd1: b = ChZero + {4'd0, s.bcd[7:4]};
        3'd2: b = ChZero + {4'd0, s.bcd[11:8]};
        3'd3: b = ChZero + {4'd0, s.bcd[15:12]};
        default: b = ChZero + {4'd0, s.bcd[19:16]};
      endcase
    end else b = trail ? ChH : ChSemi;
    return {(k == {3'd0, s.d_cnt} + 6'd1), b};
  endfunction

  function automatic logic [8:0] attr_seq(input logic [5:0] i, input tce_sts_t s);
    logic [7:0] b;
    logic e;
    e = 1'b0;
    b = ChM;
    if (i == 0) b = ChEsc;
    else if (i == 1) b = ChLbr;
    else if (s.mono) begin
      if (i == 2) b = ChZero;
      else if ((s.mono_bold || s.mono_rev) && i == 3) b = ChSemi;
      else if ((s.mono_bold || s.mono_rev) && i == 4) b = s.mono_bold ? 8'h31 : 8'h37;
      else e = 1'b1;
    end else if (s.fore_new) begin
      if (s.fore_bright) begin
        if (i == 2) b = 8'h31;
        else if (i == 3) b = ChSemi;
        else if (i == 4) b = 8'h33;
        else if (i == 5) b = ChZero + {4'd0, s.fore_map};
        else if (s.back_new && i == 6) b = ChSemi;
        else if (s.back_new && i == 7) b = 8'h34;
        else if (s.back_new && i == 8) b = ChZero + {4'd0, s.back_map};
        else e = 1'b1;
      end else begin
        if (i == 2 || i == 3) b = 8'h32;
        else if (i == 4) b = ChSemi;
        else if (i == 5) b = 8'h33;
        else if (i == 6) b = ChZero + {4'd0, s.fore_map};
        else if (s.back_new && i == 7) b = ChSemi;
        else if (s.back_new && i == 8) b = 8'h34;
        else if (s.back_new && i == 9) b = ChZero + {4'd0, s.back_map};
        else e = 1'b1;
      end
    end else begin
      if (i == 2) b = 8'h34;
      else if (i == 3) b = ChZero + {4'd0, s.back_map};
      else e = 1'b1;
    end
    return {e, b};
  endfunction

  function automatic logic [8:0] char_seq(input logic [5:0] i, input tce_sts_t s);
    logic [7:0] b;
    b = s.code;
    if (!(s.is_ctrl || s.is_csi)) return {1'b1, b};
    case (i)
      6'd0: b = ChEsc;
      6'd1: b = ChPct;
      6'd2: b = ChG;
      6'd3: b = 8'hef;
      6'd4: b = s.is_csi ? 8'h82 : 8'h80;
      6'd5: b = s.is_csi ? 8'h9b : (s.code | 8'h80);
      6'd6: b = ChEsc;
      6'd7: b = ChPct;
      default: b = ChAt;
    endcase
    return {i == 6'd8, b};
  endfunction

  logic [8:0] g;
  logic in_emit;
  logic emit;
  always_comb begin
    g = 9'd0;
    cmd_o.cmd = CmdNone;
    unique case (st_q)
      Idle: if (in_valid_i) cmd_o.cmd = CmdLoad;
      Div: if (!sts_i.div_done) cmd_o.cmd = CmdDivStep;
      ConvLd: begin
        unique case (nxt_q)
          GoRow: cmd_o.cmd = CmdDecRow;
          GoCol: cmd_o.cmd = CmdDecCol;
          CurRow: cmd_o.cmd = CmdDecCurRow;
          default: cmd_o.cmd = CmdDecCurCol;
        endcase
      end
      Conv: if (!sts_i.conv_done) cmd_o.cmd = CmdDecStep;
      GoRow, CurRow: g = dec_seq(idx_q, 1'b1, 1'b0, sts_i);
      GoCol, CurCol: g = dec_seq(idx_q, 1'b0, 1'b1, sts_i);
      Attr: g = attr_seq(idx_q, sts_i);
      Char: g = char_seq(idx_q, sts_i);
      Reset: g = {idx_q == 6'd3, (idx_q == 0) ? ChEsc : (idx_q == 1) ? ChLbr :
                  (idx_q == 2) ? ChZero : ChM};
      Done: cmd_o.cmd = CmdCommit;
      default: ;
    endcase
  end
  assign in_emit = (st_q == GoRow || st_q == GoCol || st_q == Attr || st_q == Char ||
                    st_q == Reset || st_q == CurRow || st_q == CurCol);
  assign emit = in_emit && (!ov_q || out_ready_i);
  assign in_ready_o = st_q == Idle;
  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;
  assign out_last_o = ol_q;

  logic cell_end;
  assign cell_end = (st_q == Char && g[8] && !sts_i.last) || (st_q == CurCol && g[8]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= Idle;
      nxt_q <= Idle;
      idx_q <= 6'd0;
      ov_q <= 1'b0;
      ob_q <= 8'd0;
      ol_q <= 1'b0;
    end else begin
      ov_q <= emit || (ov_q && !out_ready_i);
      unique case (st_q)
        Idle: if (in_valid_i) st_q <= Div;
        Div: if (sts_i.div_done) begin
          idx_q <= 6'd0;
          if (sts_i.first) begin
            st_q <= ConvLd;
            nxt_q <= GoRow;
          end else if (sts_i.attr_chg && (sts_i.mono || sts_i.color_chg)) st_q <= Attr;
          else st_q <= Char;
        end
        ConvLd: st_q <= Conv;
        Conv: if (sts_i.conv_done) st_q <= nxt_q;
        Done: st_q <= Idle;
        default: if (emit) begin
          ob_q <= g[7:0];
          ol_q <= cell_end;
          idx_q <= g[8] ? 6'd0 : idx_q + 6'd1;
          if (g[8]) begin
            unique case (st_q)
              GoRow: begin
                st_q <= ConvLd;
                nxt_q <= GoCol;
              end
              GoCol: st_q <= (sts_i.mono || sts_i.color_chg) ? Attr : Char;
              Attr: st_q <= Char;
              Char: begin
                if (!sts_i.last) st_q <= Done;
                else if (sts_i.mono) st_q <= Reset;
                else begin
                  st_q <= ConvLd;
                  nxt_q <= CurRow;
                end
              end
              Reset: begin
                st_q <= ConvLd;
                nxt_q <= CurRow;
              end
              CurRow: begin
                st_q <= ConvLd;
                nxt_q <= CurCol;
              end
              default: st_q <= Done;
            endcase
          end
        end
      endcase
    end
  end

  `include "text_cell_to_escape_encoder_assert.svh"
  `TCE_ASSERT_IMP(a_no_accept_busy, in_valid_i && in_ready_o, st_q == Idle)
  `TCE_ASSERT_NXT(a_hold_out, ov_q && !out_ready_i, ov_q && $stable(ob_q))
  `TCE_ASSERT_IMP(a_emit_only, in_ready_o, !in_emit)
endmodule
`default_nettype wire

>>> rtl/core/text_cell_to_escape_encoder.sv
// A cursor sequence leads the output of a first-of-run cell. A cell emits at most
// 42 bytes and prints 0, 2 or 4 decimal numbers. Offset division is bit-serial;
// each decimal number takes a shift-and-add-3 conversion. One cell in flight at a time.
// Reset: asynchronous active-low; registers to defaults, color history invalid.
`timescale 1ns / 1ps
`default_nettype none
module text_cell_to_escape_encoder import tce_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // start_offset, cell_code, cell_attr
  input  wire logic        s_axis_tuser,  // first_of_run
  input  wire logic        s_axis_tlast,  // last_of_run
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast   // last_byte
);
  tce_cmd_t cmd;
  tce_sts_t sts;
  logic [33:0] in_word;
  assign in_word = {s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tdata[31:24],
                    s_axis_tuser, s_axis_tlast};

  tce_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cell_i(in_word), .cmd_i(cmd), .sts_o(sts)
  );
  tce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_byte_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );
endmodule
`default_nettype wire
